FILE: rtl/plin_pkg.sv
// ----------------------------------------------------------------------------
// plin_pkg
// Shared types and codes for the piecewise linear interpolation table.
// ----------------------------------------------------------------------------
`default_nettype none

package plin_pkg;

  // Widest breakpoint count supported by the job word (a table of 2048 points).
  localparam int CNT_W = 11;

  // Action codes; bit 1 set selects a query.
  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_LOAD  = 2'd1;

  // Status codes.
  localparam logic [3:0] ST_CLEARED  = 4'd0;
  localparam logic [3:0] ST_STORED   = 4'd1;
  localparam logic [3:0] ST_NOT_INCR = 4'd2;
  localparam logic [3:0] ST_FULL     = 4'd3;
  localparam logic [3:0] ST_INTERP   = 4'd4;
  localparam logic [3:0] ST_FIRST    = 4'd5;
  localparam logic [3:0] ST_LAST     = 4'd6;
  localparam logic [3:0] ST_OUTSIDE  = 4'd7;
  localparam logic [3:0] ST_TOO_FEW  = 4'd8;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] key;
    logic signed [31:0] point_value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               has_value;
    logic [3:0]         status;
  } out_word_t;

  // Work handed from the front end to the back end.
  typedef enum logic [1:0] {
    JOB_DONE   = 2'd0,
    JOB_LOAD   = 2'd1,
    JOB_INTERP = 2'd2
  } job_op_t;

  typedef struct packed {
    job_op_t            op;
    logic [CNT_W-1:0]   idx;    // write index for loads, last index for searches
    logic signed [31:0] key;
    logic signed [31:0] value;  // breakpoint value for loads
    out_word_t          res;    // finished word for loads and decided cases
  } job_t;

endpackage

`default_nettype wire

FILE: rtl/plin_front.sv
// ----------------------------------------------------------------------------
// plin_front
// Accepts input words, keeps the table bookkeeping (count, end points,
// tolerance) and classifies each word into a job for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module plin_front #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [15:0]       cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire plin_pkg::in_word_t in_data,
  output logic                   job_valid,
  input  wire logic              job_ready,
  output plin_pkg::job_t         job
);
  import plin_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [CW-1:0]      count_r;
  logic [15:0]        tol_r;
  logic signed [31:0] fkey_r, fval_r, lkey_r, lval_r;

  logic signed [33:0] key34, tol34, lim34, d0, d1;
  logic               near0, near1, outside, full, not_incr, accept;

  // Wide compares against the stored end points.
  always_comb begin
    key34    = {{2{in_data.key[31]}}, in_data.key};
    tol34    = {18'd0, tol_r};
    lim34    = {{2{lkey_r[31]}}, lkey_r} + tol34;
    d0       = key34 - {{2{fkey_r[31]}}, fkey_r};
    d1       = key34 - {{2{lkey_r[31]}}, lkey_r};
    near0    = (d0 <= tol34) && (d0 >= -tol34);
    near1    = (d1 <= tol34) && (d1 >= -tol34);
    outside  = (in_data.key < fkey_r) || (in_data.key > lkey_r);
    full     = (count_r == CW'(TABLE_DEPTH));
    not_incr = (count_r != '0) && (key34 <= lim34);
  end

  assign in_ready  = job_ready;
  assign job_valid = in_valid;
  assign accept    = in_valid && job_ready;

  // Classification of the word into a job.
  always_comb begin
    job       = '0;
    job.op    = JOB_DONE;
    job.key   = in_data.key;
    job.value = in_data.point_value;
    job.idx   = CNT_W'(count_r);
    if (in_data.action[1]) begin
      if (count_r < CW'(2)) begin
        job.res.status = ST_TOO_FEW;
      end else if (near0) begin
        job.res = '{result_value: fval_r, has_value: 1'b1, status: ST_FIRST};
      end else if (near1) begin
        job.res = '{result_value: lval_r, has_value: 1'b1, status: ST_LAST};
      end else if (outside) begin
        job.res.status = ST_OUTSIDE;
      end else begin
        job.op  = JOB_INTERP;
        job.idx = CNT_W'(count_r - CW'(1));
        job.res.status = ST_INTERP;
      end
    end else if (in_data.action == ACT_LOAD) begin
      if (full) begin
        job.res.status = ST_FULL;
      end else if (not_incr) begin
        job.res.status = ST_NOT_INCR;
      end else begin
        job.op = JOB_LOAD;
        job.res.status = ST_STORED;
      end
    end else begin
      job.res.status = ST_CLEARED;
    end
  end

  // Count and tolerance.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      tol_r   <= '0;
    end else begin
      if (cfg_we) begin
        tol_r <= cfg_data;
      end
      if (accept && !in_data.action[1]) begin
        if (in_data.action == ACT_CLEAR) begin
          count_r <= '0;
        end else if (job.op == JOB_LOAD) begin
          count_r <= count_r + CW'(1);
        end
      end
    end
  end

  // End point copies for the fast checks.
  always_ff @(posedge clk) begin
    if (accept && job.op == JOB_LOAD) begin
      if (count_r == '0) begin
        fkey_r <= in_data.key;
        fval_r <= in_data.point_value;
      end
      lkey_r <= in_data.key;
      lval_r <= in_data.point_value;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/plin_fifo.sv
// ----------------------------------------------------------------------------
// plin_fifo
// Two-entry job queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module plin_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire plin_pkg::job_t push_data,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output plin_pkg::job_t      pop_data
);
  import plin_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] fill_r;
  logic       do_push, do_pop;

  assign push_ready = (fill_r != 2'd2);
  assign pop_valid  = (fill_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      if (do_push && !do_pop) fill_r <= fill_r + 2'd1;
      else if (do_pop && !do_push) fill_r <= fill_r - 2'd1;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/plin_back.sv
// ----------------------------------------------------------------------------
// plin_back
// Holds the breakpoint memories, runs the binary search, the serial divide
// for the weight and the final multiply, and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module plin_back #(
  parameter int TABLE_DEPTH = 64,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           job_valid,
  output logic                job_ready,
  input  wire plin_pkg::job_t job,
  output logic                out_valid,
  input  wire logic           out_ready,
  output plin_pkg::out_word_t out_data
);
  import plin_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int NW = $clog2(FRAC_BITS + 1);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SEARCH = 8'b0000_0010,
    S_CMP    = 8'b0000_0100,
    S_RDA    = 8'b0000_1000,
    S_RDB    = 8'b0001_0000,
    S_DIV    = 8'b0010_0000,
    S_MUL    = 8'b0100_0000,
    S_FIN    = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [31:0] key_mem [TABLE_DEPTH];
  logic signed [31:0] val_mem [TABLE_DEPTH];
  logic signed [31:0] key_q, val_q;
  logic [AW-1:0]      rd_addr, mid;
  logic [AW:0]        mid_sum;

  logic [AW-1:0]      lo_r, hi_r, mid_r;
  logic signed [31:0] key_r, ka_r, va_r;
  logic [32:0]        den_r, rem_r;
  logic signed [32:0] dv_r;
  logic [FRAC_BITS-1:0] q_r;
  logic [NW-1:0]      cnt_r;
  logic signed [33+FRAC_BITS:0] prod_r;
  logic [33:0]        rem2;
  logic               rem_ge;
  logic signed [33+FRAC_BITS:0] prod_sh;

  logic      out_valid_r;
  out_word_t out_data_r;
  logic      slot_free, take;

  assign slot_free = !out_valid_r || out_ready;
  assign job_ready = (state_r == S_IDLE) && slot_free;
  assign take      = job_valid && job_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[AW:1];

  // Read address for the synchronous memory read.
  always_comb begin
    rd_addr = lo_r;
    if (state_r == S_SEARCH) begin
      rd_addr = (lo_r < hi_r) ? mid : lo_r - AW'(1);
    end
  end

  // Breakpoint memories: one write and one read port, read data registered.
  always_ff @(posedge clk) begin
    if (take && job.op == JOB_LOAD) begin
      key_mem[job.idx[AW-1:0]] <= job.key;
      val_mem[job.idx[AW-1:0]] <= job.value;
    end
    key_q <= key_mem[rd_addr];
    val_q <= val_mem[rd_addr];
  end

  // One restoring divide step.
  assign rem2   = {rem_r, 1'b0};
  assign rem_ge = rem2 >= {1'b0, den_r};
  assign prod_sh = prod_r >>> FRAC_BITS;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (take && job.op == JOB_INTERP) state_nxt = S_SEARCH;
      S_SEARCH: state_nxt = (lo_r < hi_r) ? S_CMP : S_RDA;
      S_CMP:    state_nxt = S_SEARCH;
      S_RDA:    state_nxt = S_RDB;
      S_RDB:    state_nxt = S_DIV;
      S_DIV:    if (cnt_r == NW'(1)) state_nxt = S_MUL;
      S_MUL:    state_nxt = S_FIN;
      S_FIN:    if (slot_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((take && job.op != JOB_INTERP) || (state_r == S_FIN && slot_free)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (take) begin
          lo_r  <= AW'(1);
          hi_r  <= job.idx[AW-1:0];
          key_r <= job.key;
          if (job.op != JOB_INTERP) out_data_r <= job.res;
        end
      end
      S_SEARCH: mid_r <= mid;
      S_CMP: begin
        if (key_q > key_r) hi_r <= mid_r;
        else lo_r <= mid_r + AW'(1);
      end
      S_RDA: begin
        ka_r <= key_q;
        va_r <= val_q;
      end
      S_RDB: begin
        den_r <= 33'({key_q[31], key_q} - {ka_r[31], ka_r});
        rem_r <= 33'({key_r[31], key_r} - {ka_r[31], ka_r});
        dv_r  <= {val_q[31], val_q} - {va_r[31], va_r};
        cnt_r <= NW'(FRAC_BITS);
      end
      S_DIV: begin
        rem_r <= rem_ge ? 33'(rem2 - {1'b0, den_r}) : rem2[32:0];
        q_r   <= {q_r[FRAC_BITS-2:0], rem_ge};
        cnt_r <= cnt_r - NW'(1);
      end
      S_MUL: prod_r <= $signed({1'b0, q_r}) * dv_r;
      S_FIN: begin
        if (slot_free) begin
          out_data_r <= '{result_value: va_r + prod_sh[31:0],
                          has_value: 1'b1, status: ST_INTERP};
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/piecewise_linear_interpolator.sv
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator
// Breakpoint table with endpoint snapping and linear interpolation.
// ----------------------------------------------------------------------------
// Clear, load and the query cases decided at the ends (too few points, first
// end, last end, outside) are decided by the front end and pass through the
// back end without a search. A query that interpolates runs a binary search
// over the breakpoint memory, each probe passing through a search and a compare
// state, then two reads for the bracketing points, a restoring divide that
// yields one weight bit per cycle, one multiply and a final add. A two-word
// queue separates the classifying front end from the back end, and an output
// register holds each result until it is taken; the back end takes a new job only
// when it is free or being read. The tolerance register is set via cfg_we/cfg_data.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_interpolator #(
  parameter int TABLE_DEPTH = 64,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire plin_pkg::in_word_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output plin_pkg::out_word_t     out_data
);
  import plin_pkg::*;

  job_t push_job, pop_job;
  logic push_valid, push_ready, pop_valid, pop_ready;

  plin_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
    .clk, .rst_n, .cfg_we, .cfg_data, .in_valid, .in_ready, .in_data,
    .job_valid(push_valid), .job_ready(push_ready), .job(push_job)
  );

  plin_fifo u_fifo (
    .clk, .rst_n,
    .push_valid, .push_ready, .push_data(push_job),
    .pop_valid, .pop_ready, .pop_data(pop_job)
  );

  plin_back #(.TABLE_DEPTH(TABLE_DEPTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n,
    .job_valid(pop_valid), .job_ready(pop_ready), .job(pop_job),
    .out_valid, .out_ready, .out_data
  );

endmodule

`default_nettype wire

FILE: sim/plin_checker.sv
// ----------------------------------------------------------------------------
// plin_checker
// Watches both channels of the interpolation table, predicts each output word
// from the accepted input words and compares them field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module plin_checker #(
  parameter int TABLE_DEPTH = 64,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [15:0]         cfg_data,
  input  wire logic                in_valid,
  input  wire logic                in_ready,
  input  wire plin_pkg::in_word_t  in_data,
  input  wire logic                out_valid,
  input  wire logic                out_ready,
  input  wire plin_pkg::out_word_t out_data,
  output int                       error_count,
  output int                       pending_count
);
  import plin_pkg::*;

  logic signed [31:0] bp_key [TABLE_DEPTH];
  logic signed [31:0] bp_val [TABLE_DEPTH];
  int                 bp_count;
  logic [15:0]        tol_reg;
  out_word_t          expected_words [$];

  // Apply one input word to the table copy and return the word it should yield.
  function automatic out_word_t table_step(in_word_t w);
    out_word_t          r;
    longint             zi, z0, z1, num, den, wt, one, acc, tol;
    int                 k;
    r = '0;
    tol = longint'(tol_reg);
    if (w.action == ACT_CLEAR) begin
      bp_count = 0;
      r.status = ST_CLEARED;
    end else if (w.action == ACT_LOAD) begin
      if (bp_count >= TABLE_DEPTH) begin
        r.status = ST_FULL;
      end else if (bp_count > 0 &&
                   longint'(w.key) <= longint'(bp_key[bp_count-1]) + tol) begin
        r.status = ST_NOT_INCR;
      end else begin
        bp_key[bp_count] = w.key;
        bp_val[bp_count] = w.point_value;
        bp_count++;
        r.status = ST_STORED;
      end
    end else if (bp_count < 2) begin
      r.status = ST_TOO_FEW;
    end else begin
      zi = longint'(w.key);
      z0 = longint'(bp_key[0]);
      z1 = longint'(bp_key[bp_count-1]);
      if ((zi - z0 < 0 ? z0 - zi : zi - z0) <= tol) begin
        r.result_value = bp_val[0];
        r.has_value = 1'b1;
        r.status = ST_FIRST;
      end else if ((zi - z1 < 0 ? z1 - zi : zi - z1) <= tol) begin
        r.result_value = bp_val[bp_count-1];
        r.has_value = 1'b1;
        r.status = ST_LAST;
      end else if (zi < z0 || zi > z1) begin
        r.status = ST_OUTSIDE;
      end else begin
        // Bracketing pair: first key above the query, kept inside the table.
        k = 0;
        while (k < bp_count && longint'(bp_key[k]) <= zi) k++;
        if (k == 0) k = 1;
        if (k > bp_count - 1) k = bp_count - 1;
        num = zi - longint'(bp_key[k-1]);
        den = longint'(bp_key[k]) - longint'(bp_key[k-1]);
        if (num < 0) num = 0;
        if (den <= 0) den = 1;
        wt = (num <<< FRAC_BITS) / den;
        one = longint'(1) <<< FRAC_BITS;
        if (wt > one) wt = one;
        acc = (one - wt) * longint'(bp_val[k-1]) + wt * longint'(bp_val[k]);
        r.result_value = 32'(acc >>> FRAC_BITS);
        r.has_value = 1'b1;
        r.status = ST_INTERP;
      end
    end
    return r;
  endfunction

  assign pending_count = expected_words.size();

  // Track configuration, predict on input words and check output words.
  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst_n) begin
      bp_count <= 0;
      tol_reg <= '0;
      error_count <= 0;
      expected_words.delete();
    end else begin
      if (cfg_we) tol_reg <= cfg_data;
      if (in_valid && in_ready) expected_words.push_back(table_step(in_data));
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word %h", $time, out_data);
          error_count <= error_count + 1;
        end else begin
          exp_w = expected_words.pop_front();
          if (out_data.result_value !== exp_w.result_value ||
              out_data.has_value !== exp_w.has_value ||
              out_data.status !== exp_w.status) begin
            $display("%0t: mismatch expected value %0d has %0b status %0d, got %0d %0b %0d",
                     $time, exp_w.result_value, exp_w.has_value, exp_w.status,
                     out_data.result_value, out_data.has_value, out_data.status);
            error_count <= error_count + 1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives clear, load and query words into the interpolation table under three
// flow-control mixes and several tolerance settings; the checker judges.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import plin_pkg::*;

  localparam logic [1:0] ACT_QUERY     = 2'd2;
  localparam logic [1:0] ACT_QUERY_ALT = 2'd3;
  localparam int         CYCLE_LIMIT   = 400000;

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  logic [15:0] cfg_data;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;
  int        error_count;
  int        pending_count;
  int        send_idle_pct;
  int        recv_idle_pct;
  int        cycle_count;
  logic signed [31:0] last_key;

  piecewise_linear_interpolator i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  plin_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .error_count  (error_count),
    .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver stalls at random.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Send one word, with a random gap first, and wait until it is accepted.
  // Valid stays high after acceptance so that words can follow back to back.
  task automatic send_word(logic [1:0] act, logic signed [31:0] k,
                           logic signed [31:0] v);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= '{action: act, key: k, point_value: v};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [15:0] t);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= t;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Build a table of ascending keys with random spacing, mixed with clears, random loads and queries.
  task automatic random_phase(int words, logic [15:0] tol);
    int n;
    int span;
    logic signed [31:0] k;
    write_tolerance(tol);
    span = ($urandom_range(3) == 0) ? 32'h7fff_ffff : 32'h0010_0000;
    send_word(ACT_CLEAR, $urandom, $urandom);
    last_key = -$signed(span / 2);
    n = 0;
    while (n < words) begin
      case ($urandom_range(19))
        0: begin
          send_word(ACT_CLEAR, $urandom, $urandom);
          last_key = -$signed($urandom_range(span / 2));
        end
        1, 2: send_word(ACT_LOAD, $urandom, $urandom);
        3, 4, 5, 6, 7: begin
          k = last_key + tol + 1 + $urandom_range(($urandom_range(1) == 0) ? 70000 : 1 << 22);
          if (k > last_key) begin
            send_word(ACT_LOAD, k, $urandom);
            last_key = k;
          end
        end
        8: send_word(ACT_QUERY_ALT, $urandom, $urandom);
        9: send_word(ACT_QUERY, last_key + $signed($urandom_range(2 * tol + 2)) - tol - 1,
                     $urandom);
        default: send_word(ACT_QUERY, last_key - $urandom_range(1 << 23), $urandom);
      endcase
      n++;
    end
  endtask

  initial begin
    int i;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cycle_count = 0;
    send_idle_pct = 17;
    recv_idle_pct = 60;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: short table, extremes, both endpoints, unused action code.
    send_word(ACT_QUERY, 0, 0);
    send_word(ACT_LOAD, 32'sh8000_0000, 32'sh7fff_ffff);
    send_word(ACT_QUERY, 0, 0);
    send_word(ACT_LOAD, 32'sh8000_0000, 0);
    send_word(ACT_LOAD, 0, 32'sh8000_0000);
    send_word(ACT_LOAD, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_word(ACT_QUERY, 32'sh8000_0000, 0);
    send_word(ACT_QUERY, 32'sh7fff_ffff, 32'hffff_ffff);
    send_word(ACT_QUERY, 32'sh4000_0000, 0);
    send_word(ACT_QUERY, -1, 0);
    send_word(ACT_QUERY_ALT, 1, 0);
    send_word(ACT_CLEAR, 32'hffff_ffff, 32'hffff_ffff);
    send_word(ACT_LOAD, -5, 100);
    send_word(ACT_LOAD, 5, -100);
    send_word(ACT_QUERY, 10, 0);
    send_word(ACT_QUERY, -10, 0);

    // Loads and queries at the widest tolerance.
    write_tolerance(16'hffff);
    send_word(ACT_LOAD, 10, 0);
    send_word(ACT_LOAD, 32'h0003_0000, 7);
    send_word(ACT_QUERY, 32'h0001_0000, 0);
    send_word(ACT_QUERY, 32'h0002_0000, 0);
    send_word(ACT_QUERY, 32'h0001_8000, 0);

    // Fill the table to its depth, then overflow.
    write_tolerance(16'h0000);
    send_word(ACT_CLEAR, 0, 0);
    for (i = 0; i < 66; i++) send_word(ACT_LOAD, i * 1000, $urandom);
    send_word(ACT_QUERY, 31500, 0);
    send_word(ACT_QUERY, 64999, 0);

    random_phase(500, 16'h0000);
    send_idle_pct = 60;
    recv_idle_pct = 17;
    random_phase(250, 16'hffff);
    // Hold off until every word has come back.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    random_phase(250, 16'($urandom));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(500, 16'($urandom_range(255)));

    drain();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
